// File: rtl/stt_pkg.sv
// Shared types, codes and constants for the timer slot table.
`default_nettype none

package stt_pkg;

    localparam int SLOTS_DEFAULT = 10;
    localparam int PERIOD_W      = 16;
    localparam int SLOT_W        = 4;
    localparam int IN_DATA_W     = 24;
    localparam int OUT_DATA_W    = 8;

    typedef enum logic [1:0] {
        ACT_TICK       = 2'd0,
        ACT_CREATE_PER = 2'd1,
        ACT_CREATE_ONE = 2'd2,
        ACT_DESTROY    = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        MODE_FREE     = 2'd0,
        MODE_PERIODIC = 2'd1,
        MODE_ONESHOT  = 2'd2
    } mode_t;

    localparam logic KIND_REPLY = 1'b0;
    localparam logic KIND_FIRE  = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TICK,
        ST_CREATE,
        ST_DESTROY,
        ST_FLUSH
    } state_t;

    typedef struct packed {
        logic load;
        logic tick_step;
        logic create_take;
        logic create_fail;
        logic destroy;
        logic flush;
        logic advance;
    } stt_cmd_t;

    typedef struct packed {
        logic at_end;
        logic active;
        logic fires;
        logic pend_valid;
        logic out_free;
    } stt_status_t;

endpackage

`default_nettype wire

// File: rtl/stt_ctrl.sv
// Controller state machine that sequences the slot scans.
`default_nettype none

module stt_ctrl
    import stt_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire action_t     action,
    input  wire stt_status_t st,
    output stt_cmd_t         cmd
);

    state_t state_reg;
    state_t state_next;
    logic   tick_stall;

    assign tick_stall = st.fires && st.pend_valid && !st.out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    unique case (action) inside
                        ACT_TICK: state_next = ST_TICK;
                        ACT_CREATE_PER, ACT_CREATE_ONE: state_next = ST_CREATE;
                        default: state_next = ST_DESTROY;
                    endcase
                end
            end
            ST_TICK: begin
                if (!tick_stall && st.at_end) begin
                    state_next = ST_FLUSH;
                end
            end
            ST_CREATE: begin
                if ((!st.active || st.at_end) && st.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            ST_DESTROY: begin
                state_next = ST_IDLE;
            end
            ST_FLUSH: begin
                if (!st.pend_valid || st.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            ST_TICK: begin
                cmd.tick_step = !tick_stall;
            end
            ST_CREATE: begin
                if (!st.active) begin
                    cmd.create_take = st.out_free;
                end else if (st.at_end) begin
                    cmd.create_fail = st.out_free;
                end else begin
                    cmd.advance = 1'b1;
                end
            end
            ST_DESTROY: begin
                cmd.destroy = 1'b1;
            end
            ST_FLUSH: begin
                cmd.flush = st.pend_valid && st.out_free;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("word accepted while an item is in progress");

    a_pend_flushed: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> !st.pend_valid)
        else $error("fire result left pending at item end");

endmodule

`default_nettype wire

// File: rtl/stt_dpath.sv
// Datapath: slot table, scan index, pending fire and output register.
`default_nettype none

module stt_dpath
    import stt_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEFAULT
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire action_t               action,
    input  wire logic [IN_DATA_W-1:0]  s_tdata,
    input  wire stt_cmd_t              cmd,
    output stt_status_t                st,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic                       m_tuser,
    output logic [OUT_DATA_W-1:0]      m_tdata,
    output logic                       m_tlast
);

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    mode_t                 mode_reg   [SLOTS];
    logic [PERIOD_W-1:0]   period_reg [SLOTS];
    logic [PERIOD_W-1:0]   remain_reg [SLOTS];

    action_t               action_reg;
    logic [PERIOD_W-1:0]   new_period_reg;
    logic [SLOT_W-1:0]     num_reg;
    logic [IDX_W-1:0]      idx_reg;

    logic                  pend_valid_reg;
    logic [SLOT_W-1:0]     pend_slot_reg;
    logic                  out_valid_reg;
    logic                  out_kind_reg;
    logic [SLOT_W-1:0]     out_slot_reg;
    logic                  out_last_reg;

    mode_t                 cur_mode;
    logic [PERIOD_W-1:0]   cur_remain;
    logic [SLOT_W-1:0]     cur_slot;
    logic [5:0]            idx_plus;
    logic [5:0]            dest_num;
    logic                  dest_ok;
    logic [IDX_W-1:0]      dest_idx;
    logic                  out_free;

    assign cur_mode   = mode_reg[idx_reg];
    assign cur_remain = remain_reg[idx_reg];
    assign idx_plus   = 6'(idx_reg) + 6'd1;
    assign cur_slot   = idx_plus[SLOT_W-1:0];
    assign dest_num   = 6'(num_reg);
    assign dest_ok    = (dest_num != 6'd0) && (dest_num <= 6'(SLOTS));
    assign dest_idx   = IDX_W'(dest_num - 6'd1);
    assign out_free   = !out_valid_reg || m_tready;

    assign st.at_end     = (idx_reg == IDX_W'(SLOTS - 1));
    assign st.active     = (cur_mode == MODE_PERIODIC) || (cur_mode == MODE_ONESHOT);
    assign st.fires      = st.active && (cur_remain == PERIOD_W'(1));
    assign st.pend_valid = pend_valid_reg;
    assign st.out_free   = out_free;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            action_reg     <= action;
            new_period_reg <= s_tdata[PERIOD_W-1:0];
            num_reg        <= s_tdata[PERIOD_W+SLOT_W-1:PERIOD_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg <= '0;
        end else if (cmd.load) begin
            idx_reg <= '0;
        end else if (cmd.tick_step || cmd.advance) begin
            idx_reg <= idx_reg + IDX_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < SLOTS; i++) begin
                mode_reg[i] <= MODE_FREE;
            end
        end else if (cmd.tick_step && st.fires && cur_mode == MODE_ONESHOT) begin
            mode_reg[idx_reg] <= MODE_FREE;
        end else if (cmd.create_take) begin
            mode_reg[idx_reg] <= (action_reg == ACT_CREATE_PER) ? MODE_PERIODIC
                                                                : MODE_ONESHOT;
        end else if (cmd.destroy && dest_ok) begin
            mode_reg[dest_idx] <= MODE_FREE;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.tick_step && st.active) begin
            if (st.fires) begin
                remain_reg[idx_reg] <= (cur_mode == MODE_PERIODIC) ? period_reg[idx_reg]
                                                                   : '0;
                if (cur_mode != MODE_PERIODIC) begin
                    period_reg[idx_reg] <= '0;
                end
            end else begin
                remain_reg[idx_reg] <= cur_remain - PERIOD_W'(1);
            end
        end else if (cmd.create_take) begin
            period_reg[idx_reg] <= new_period_reg;
            remain_reg[idx_reg] <= new_period_reg;
        end else if (cmd.destroy && dest_ok) begin
            period_reg[dest_idx] <= '0;
            remain_reg[dest_idx] <= '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_valid_reg <= 1'b0;
        end else if (cmd.tick_step && st.fires) begin
            pend_valid_reg <= 1'b1;
        end else if (cmd.flush) begin
            pend_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.tick_step && st.fires) begin
            pend_slot_reg <= cur_slot;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if ((cmd.tick_step && st.fires && pend_valid_reg) || cmd.flush
                     || cmd.create_take || cmd.create_fail) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.tick_step && st.fires && pend_valid_reg) begin
            out_kind_reg <= KIND_FIRE;
            out_slot_reg <= pend_slot_reg;
            out_last_reg <= 1'b0;
        end else if (cmd.flush) begin
            out_kind_reg <= KIND_FIRE;
            out_slot_reg <= pend_slot_reg;
            out_last_reg <= 1'b1;
        end else if (cmd.create_take) begin
            out_kind_reg <= KIND_REPLY;
            out_slot_reg <= cur_slot;
            out_last_reg <= 1'b1;
        end else if (cmd.create_fail) begin
            out_kind_reg <= KIND_REPLY;
            out_slot_reg <= '0;
            out_last_reg <= 1'b1;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tdata  = OUT_DATA_W'(out_slot_reg);
    assign m_tlast  = out_last_reg;

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.tick_step && st.fires && pend_valid_reg) |-> out_free)
        else $error("output word overwritten before it was taken");

    a_take_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.create_take |-> !st.active)
        else $error("create took an active slot");

endmodule

`default_nettype wire

// File: rtl/software_timer_slot_table.sv
// A tick scans one slot per cycle unless a fire word waits on a full output, then sends the last fire word.
// A create scans to the lowest free slot; a destroy clears the named slot without a scan.
// Throughput: one item at a time; the slot scan through one table port sets the rate.
// Output backpressure stalls a tick scan only when a second fire word meets a full output;
// the create reply and the closing fire word of a tick wait for a free output.
// Reset: synchronous, active low; all slots free, no word pending or offered.
`default_nettype none

module software_timer_slot_table
    import stt_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEFAULT
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [IN_DATA_W-1:0]  s_tdata,   // [15:0] period, [19:16] slot_number
    input  wire logic [1:0]            s_tuser,   // [1:0] action
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [OUT_DATA_W-1:0]      m_tdata,   // [3:0] reported_slot
    output logic                       m_tuser,   // [0] event_kind
    output logic                       m_tlast
);

    stt_cmd_t    cmd;
    stt_status_t st;
    action_t     action;

    assign action = action_t'(s_tuser);

    stt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .action   (action),
        .st       (st),
        .cmd      (cmd)
    );

    stt_dpath #(
        .SLOTS (SLOTS)
    ) u_dpath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .action   (action),
        .s_tdata  (s_tdata),
        .cmd      (cmd),
        .st       (st),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tuser  (m_tuser),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire
